// ===== hw/rtl/ismf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ismf_pkg;

  // Lattice geometry: SIDE x SIDE spins, one lattice row per memory word.
  localparam int SIDE   = 64;
  localparam int IDX_W  = $clog2(SIDE);

  // Field widths.
  localparam int THRESH_W = 17;
  localparam int RAND_W   = 16;
  localparam int DE_W     = 5;
  localparam int ENERGY_W = 15;
  localparam int MAG_W    = 14;
  localparam int CNT_W    = 3;

  // Stream packing.
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Register indexes of the configuration port.
  localparam logic CFG_THRESH_FOUR  = 1'b0;
  localparam logic CFG_THRESH_EIGHT = 1'b1;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_TRIAL = 1'b1;

  // Totals after reset: every spin +1.
  localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SIDE * SIDE);
  localparam logic signed [MAG_W-1:0]    MAG_RESET    = MAG_W'(SIDE * SIDE);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_UP,
    ST_RD_MID,
    ST_RD_DN,
    ST_ACC_DN,
    ST_COMMIT
  } seq_state_e;

  // Steering from the sequencer to the neighbor unit.
  typedef struct packed {
    logic clearing;
    logic nb_clr;
    logic add_up;
    logic add_mid;
    logic add_dn;
    logic commit;
  } ctl_t;

  // One result item.
  typedef struct packed {
    logic                       site_spin;
    logic signed [MAG_W-1:0]    spin_sum;
    logic signed [ENERGY_W-1:0] total_energy;
    logic signed [DE_W-1:0]     delta_energy;
    logic                       accepted;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ising_metropolis_flip.sv =====
// A result is registered at the output after the states RD_UP, RD_MID, RD_DN,
// ACC_DN and COMMIT, which waits while the output stalls; no new item is taken
// before then. The target row and the rows above and below are read in turn
// through the single read port of the lattice memory. Reset: async, active low;
// a clear pass then sets all rows to +1 spins, taking config writes but no input.
`timescale 1ns / 1ps
`default_nettype none

module ising_metropolis_flip
  import ismf_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write port.
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [THRESH_W-1:0]    cfg_wdata_i,
  // Input stream.
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // row[5:0], col[11:6], spin_value[12], random_word[28:13], zero[31:29]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // kind[0]
  input  wire logic                   s_axis_tuser,
  // Result stream.
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // accepted[0], delta_energy[5:1], total_energy[20:6], spin_sum[34:21],
  // site_spin[35], zero[39:36]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  logic [THRESH_W-1:0] th_four_q, th_eight_q;
  logic                kind_q, spin_value_q;
  logic [IDX_W-1:0]    row_q, col_q;
  logic [RAND_W-1:0]   rnd_q;
  logic                out_valid_q;
  result_t             out_res_q;

  logic                in_ready, in_acc, out_busy;
  ctl_t                ctl;
  logic                re, we;
  logic [IDX_W-1:0]    raddr, waddr;
  logic [SIDE-1:0]     rdata, new_row, wdata;
  result_t             res;

  // Threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_four_q  <= '0;
      th_eight_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESH_FOUR:  th_four_q  <= cfg_wdata_i;
        CFG_THRESH_EIGHT: th_eight_q <= cfg_wdata_i;
        default:          th_four_q  <= th_four_q;
      endcase
    end
  end

  // Capture the item on its transaction.
  assign s_axis_tready = in_ready;
  assign in_acc        = s_axis_tvalid && in_ready;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q       <= s_axis_tuser;
      row_q        <= s_axis_tdata[IDX_W-1:0];
      col_q        <= s_axis_tdata[11:6];
      spin_value_q <= s_axis_tdata[12];
      rnd_q        <= s_axis_tdata[28:13];
    end
  end

  // Output register.
  assign out_busy = out_valid_q && !m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.commit) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q};

  // Sequencer.
  ismf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_busy_i (out_busy),
    .row_i      (row_q),
    .in_ready_o (in_ready),
    .ctl_o      (ctl),
    .re_o       (re),
    .raddr_o    (raddr),
    .we_o       (we),
    .waddr_o    (waddr)
  );

  // Lattice memory; the clear pass writes rows of +1 spins.
  assign wdata = ctl.clearing ? {SIDE{1'b1}} : new_row;

  ismf_spin_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Neighbor count, decision and running totals.
  ismf_eval u_eval (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .rdata_i        (rdata),
    .kind_i         (kind_q),
    .col_i          (col_q),
    .spin_value_i   (spin_value_q),
    .random_word_i  (rnd_q),
    .thresh_four_i  (th_four_q),
    .thresh_eight_i (th_eight_q),
    .result_o       (res),
    .new_row_o      (new_row)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ismf_spin_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ismf_spin_ram
  import ismf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire logic [SIDE-1:0]  wdata_i,
  input  wire logic             re_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output logic      [SIDE-1:0]  rdata_o
);

  // One lattice row per word.
  logic [SIDE-1:0] mem [SIDE];
  logic [SIDE-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ismf_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ismf_eval
  import ismf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctl_t                ctl_i,
  input  wire logic [SIDE-1:0]     rdata_i,
  input  wire logic                kind_i,
  input  wire logic [IDX_W-1:0]    col_i,
  input  wire logic                spin_value_i,
  input  wire logic [RAND_W-1:0]   random_word_i,
  input  wire logic [THRESH_W-1:0] thresh_four_i,
  input  wire logic [THRESH_W-1:0] thresh_eight_i,
  output result_t                  result_o,
  output logic      [SIDE-1:0]     new_row_o
);

  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [SIDE-1:0]            mid_q;
  logic signed [ENERGY_W-1:0] energy_q, energy_d;
  logic signed [MAG_W-1:0]    mag_q, mag_d;

  logic [IDX_W-1:0]           col_lf, col_rt;
  logic [CNT_W-1:0]           add_val;
  logic                       s_bit;
  logic signed [DE_W:0]       de_wide;
  logic signed [DE_W-1:0]     de;
  logic                       rnd_lt_four, rnd_lt_eight;
  logic                       flip;

  // Columns wrap around the torus.
  assign col_lf = col_i - IDX_W'(1);
  assign col_rt = col_i + IDX_W'(1);

  // Shared counter of +1 neighbors, fed one read step at a time.
  always_comb begin
    add_val = '0;
    if (ctl_i.add_up || ctl_i.add_dn) begin
      add_val = CNT_W'(rdata_i[col_i]);
    end else if (ctl_i.add_mid) begin
      add_val = CNT_W'(rdata_i[col_lf]) + CNT_W'(rdata_i[col_rt]);
    end
    cnt_d = ctl_i.nb_clr ? '0 : cnt_q + add_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // The target row is kept for the write back.
  always_ff @(posedge clk_i) begin
    if (ctl_i.add_mid) begin
      mid_q <= rdata_i;
    end
  end

  // dE = 2*s*(2*cnt - 4), i.e. +-(4*cnt - 8).
  assign s_bit = mid_q[col_i];
  always_comb begin
    de_wide = $signed({1'b0, cnt_q, 2'b00}) - (DE_W + 1)'(8);
    if (!s_bit) begin
      de_wide = -de_wide;
    end
    de = de_wide[DE_W-1:0];
  end

  // Acceptance rule.
  assign rnd_lt_four  = {1'b0, random_word_i} < thresh_four_i;
  assign rnd_lt_eight = {1'b0, random_word_i} < thresh_eight_i;

  always_comb begin
    if (kind_i == KIND_LOAD) begin
      flip = (spin_value_i != s_bit);
    end else begin
      flip = (de <= DE_W'(0))
          || ((de == DE_W'(4)) && rnd_lt_four)
          || ((de == DE_W'(8)) && rnd_lt_eight);
    end
  end

  // Totals after this item.
  always_comb begin
    energy_d = energy_q;
    mag_d    = mag_q;
    if (flip) begin
      energy_d = energy_q + ENERGY_W'(de);
      mag_d    = s_bit ? mag_q - MAG_W'(2) : mag_q + MAG_W'(2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= ENERGY_RESET;
      mag_q    <= MAG_RESET;
    end else if (ctl_i.commit) begin
      energy_q <= energy_d;
      mag_q    <= mag_d;
    end
  end

  // Result fields and the row to write back.
  always_comb begin
    result_o.accepted     = flip;
    result_o.delta_energy = ((kind_i == KIND_LOAD) && !flip) ? '0 : de;
    result_o.total_energy = energy_d;
    result_o.spin_sum     = mag_d;
    result_o.site_spin    = s_bit ^ flip;
    new_row_o             = mid_q;
    new_row_o[col_i]      = s_bit ^ flip;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ismf_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ismf_seq
  import ismf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             out_busy_i,
  input  wire logic [IDX_W-1:0] row_i,
  output logic                  in_ready_o,
  output ctl_t                  ctl_o,
  output logic                  re_o,
  output logic [IDX_W-1:0]      raddr_o,
  output logic                  we_o,
  output logic [IDX_W-1:0]      waddr_o
);

  seq_state_e       state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == IDX_W'(SIDE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RD_UP;
        end
      end
      ST_RD_UP:  state_d = ST_RD_MID;
      ST_RD_MID: state_d = ST_RD_DN;
      ST_RD_DN:  state_d = ST_ACC_DN;
      ST_ACC_DN: state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (!out_busy_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Clear pass counter, one row per cycle.
  assign clr_d = (state_q == ST_CLEAR) ? clr_q + IDX_W'(1) : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Outputs.
  always_comb begin
    in_ready_o    = 1'b0;
    ctl_o         = '0;
    re_o          = 1'b0;
    raddr_o       = row_i;
    we_o          = 1'b0;
    waddr_o       = row_i;
    case (state_q)
      ST_CLEAR: begin
        ctl_o.clearing = 1'b1;
        we_o           = 1'b1;
        waddr_o        = clr_q;
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        ctl_o.nb_clr = 1'b1;
      end
      ST_RD_UP: begin
        re_o    = 1'b1;
        raddr_o = row_i - IDX_W'(1);
      end
      ST_RD_MID: begin
        re_o         = 1'b1;
        ctl_o.add_up = 1'b1;
      end
      ST_RD_DN: begin
        re_o          = 1'b1;
        raddr_o       = row_i + IDX_W'(1);
        ctl_o.add_mid = 1'b1;
      end
      ST_ACC_DN: begin
        ctl_o.add_dn = 1'b1;
      end
      ST_COMMIT: begin
        if (!out_busy_i) begin
          ctl_o.commit = 1'b1;
          we_o         = 1'b1;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
